// ----- hw/rtl/ptme_pkg.sv -----
// shared types and constants for the page table map/unmap engine
package ptme_pkg;

    localparam int POOL_FRAMES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int IDX_W       = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_IDX_W = $clog2(POOL_FRAMES);
    localparam int FRAME_CNT_W = $clog2(POOL_FRAMES + 1);
    localparam int CNT_W       = (FRAME_CNT_W > 7) ? FRAME_CNT_W : 7;
    localparam int STORE_DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = 64;
    localparam int PFN_W       = 40;
    localparam int VPN_W       = 36;
    localparam int FLAGS_W     = 12;
    localparam int LIMIT_W     = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FLAGS_W-1:0] LINK_FLAGS = 12'h007;

    localparam logic MODE_MAP   = 1'b0;
    localparam logic MODE_UNMAP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_FRAME = 2'd1,
        STAT_NO_MAP   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_LEAF,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/ptme_ram.sv -----
// generic simple dual-port ram with registered read
module ptme_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 512,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/page_table_map_unmap_engine.sv -----
// page table map/unmap engine: walks and builds a four-level table in a frame pool
// walk: each level is a ram read state then a check/link-write state on the single table
//   store; a walk that stops at level k (0..2) goes to the done state from that check, and
//   a full walk writes the leaf before it; o_done is high in the done state
// throughput: one request per walk, a new request is taken in the o_done cycle
// reset: after i_rst_n the whole store is swept to zero, one entry a cycle, with busy
//   high; config writes are taken whenever i_rst_n is high; results cannot be stalled
module page_table_map_unmap_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_mode,
    input  logic [ptme_pkg::VPN_W-1:0]       i_virt_page,
    input  logic [ptme_pkg::PFN_W-1:0]       i_phys_frame,
    input  logic [ptme_pkg::FLAGS_W-1:0]     i_leaf_flags,
    input  logic                             i_no_execute,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic                             o_tlb_invalidate,
    output logic [6:0]                       o_frames_in_use,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ptme_pkg::PFN_W-1:0]       i_cfg_data
);

    localparam int FIW = ptme_pkg::FRAME_IDX_W;
    localparam int CW  = ptme_pkg::CNT_W;
    localparam int AW  = ptme_pkg::ADDR_W;
    localparam int XW  = ptme_pkg::IDX_W;
    localparam int PW  = ptme_pkg::PFN_W;
    localparam int EW  = ptme_pkg::ENTRY_W;

    ptme_pkg::t_state  r_state, n_state;
    ptme_pkg::t_status r_status, n_status;

    logic [PW-1:0]                     r_base;
    logic [ptme_pkg::LIMIT_W-1:0]      r_limit;
    logic [CW-1:0]                     r_next_free, n_next_free;
    logic [AW-1:0]                     r_clr_addr, n_clr_addr;
    logic [FIW-1:0]                    r_table, n_table;
    logic [1:0]                        r_lvl, n_lvl;
    logic                              r_tlb, n_tlb;

    logic                              r_mode, n_mode;
    logic [ptme_pkg::VPN_W-1:0]        r_vpage, n_vpage;
    logic [PW-1:0]                     r_pfn, n_pfn;
    logic [ptme_pkg::FLAGS_W-1:0]      r_flags, n_flags;
    logic                              r_nx, n_nx;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;

    logic              accept;
    logic [XW-1:0]     cur_ix;
    logic [PW-1:0]     link_idx;
    logic              follow;
    logic [CW-1:0]     limit;
    logic              exhausted;
    logic              alloc;
    logic [PW-1:0]     new_pfn;

    ptme_ram #(
        .WIDTH (EW),
        .DEPTH (ptme_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept = start && !busy;

    always_comb begin
        case (r_lvl)
            2'd0:    cur_ix = r_vpage[35:27];
            2'd1:    cur_ix = r_vpage[26:18];
            default: cur_ix = r_vpage[17:9];
        endcase
    end

    // a present link counts only if it points at a frame already handed out
    assign link_idx  = ram_rdata[51:12] - r_base;
    assign follow    = ram_rdata[0] && (link_idx < PW'(r_next_free));
    assign limit     = (CW'(r_limit) < CW'(ptme_pkg::POOL_FRAMES)) ?
                       CW'(r_limit) : CW'(ptme_pkg::POOL_FRAMES);
    assign exhausted = (r_next_free >= limit);
    assign alloc     = !follow && (r_mode == ptme_pkg::MODE_MAP) && !exhausted;
    assign new_pfn   = r_base + PW'(r_next_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptme_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(ptme_pkg::STORE_DEPTH - 1)) begin
                    n_state = ptme_pkg::ST_IDLE;
                end
            end
            ptme_pkg::ST_IDLE, ptme_pkg::ST_DONE: begin
                n_state = start ? ptme_pkg::ST_READ : ptme_pkg::ST_IDLE;
            end
            ptme_pkg::ST_READ: begin
                n_state = ptme_pkg::ST_CHECK;
            end
            ptme_pkg::ST_CHECK: begin
                if (follow || alloc) begin
                    n_state = (r_lvl == 2'd2) ? ptme_pkg::ST_LEAF : ptme_pkg::ST_READ;
                end else begin
                    n_state = ptme_pkg::ST_DONE;
                end
            end
            ptme_pkg::ST_LEAF: begin
                n_state = ptme_pkg::ST_DONE;
            end
            default: begin
                n_state = ptme_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        busy        = 1'b1;
        o_done      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = {r_table, cur_ix};
        ram_wdata   = '0;
        ram_raddr   = {r_table, cur_ix};
        n_next_free = r_next_free;
        n_clr_addr  = r_clr_addr;
        n_table     = r_table;
        n_lvl       = r_lvl;
        n_status    = r_status;
        n_tlb       = r_tlb;
        n_mode      = r_mode;
        n_vpage     = r_vpage;
        n_pfn       = r_pfn;
        n_flags     = r_flags;
        n_nx        = r_nx;
        unique case (r_state)
            ptme_pkg::ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            ptme_pkg::ST_IDLE, ptme_pkg::ST_DONE: begin
                busy   = 1'b0;
                o_done = (r_state == ptme_pkg::ST_DONE);
                if (accept) begin
                    n_mode   = i_mode;
                    n_vpage  = i_virt_page;
                    n_pfn    = i_phys_frame;
                    n_flags  = i_leaf_flags;
                    n_nx     = i_no_execute;
                    n_table  = '0;
                    n_lvl    = 2'd0;
                    n_status = ptme_pkg::STAT_DONE;
                    n_tlb    = 1'b0;
                end
            end
            ptme_pkg::ST_READ: begin
            end
            ptme_pkg::ST_CHECK: begin
                if (follow) begin
                    n_table = link_idx[FIW-1:0];
                    n_lvl   = r_lvl + 2'd1;
                end else if (alloc) begin
                    ram_we      = 1'b1;
                    ram_wdata   = {12'h000, new_pfn, ptme_pkg::LINK_FLAGS};
                    n_next_free = r_next_free + CW'(1);
                    n_table     = r_next_free[FIW-1:0];
                    n_lvl       = r_lvl + 2'd1;
                end else begin
                    n_status = (r_mode == ptme_pkg::MODE_MAP) ?
                               ptme_pkg::STAT_NO_FRAME : ptme_pkg::STAT_NO_MAP;
                end
            end
            ptme_pkg::ST_LEAF: begin
                ram_we    = 1'b1;
                ram_waddr = {r_table, r_vpage[XW-1:0]};
                if (r_mode == ptme_pkg::MODE_MAP) begin
                    ram_wdata = {r_nx, 11'h000, r_pfn, r_flags};
                end else begin
                    ram_wdata = '0;
                    n_tlb     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status         = r_status;
    assign o_tlb_invalidate = r_tlb;
    assign o_frames_in_use  = r_next_free[6:0];
    assign o_cfg_ready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptme_pkg::ST_CLEAR;
            r_status    <= ptme_pkg::STAT_DONE;
            r_tlb       <= 1'b0;
            r_base      <= '0;
            r_limit     <= 7'd64;
            r_next_free <= CW'(1);
            r_clr_addr  <= '0;
            r_table     <= '0;
            r_lvl       <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_tlb       <= n_tlb;
            r_next_free <= n_next_free;
            r_clr_addr  <= n_clr_addr;
            r_table     <= n_table;
            r_lvl       <= n_lvl;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ptme_pkg::CFG_POOL_BASE:   r_base  <= i_cfg_data;
                    ptme_pkg::CFG_FRAME_LIMIT: r_limit <= i_cfg_data[ptme_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_vpage <= n_vpage;
        r_pfn   <= n_pfn;
        r_flags <= n_flags;
        r_nx    <= n_nx;
    end

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !start |=> !o_done)
        else $error("done strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_done)
        else $error("accepted request did not start a walk");

    a_frames_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free >= CW'(1) && r_next_free <= CW'(ptme_pkg::POOL_FRAMES))
        else $error("frame counter out of pool range");

    a_no_frame_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ptme_pkg::STAT_NO_FRAME |-> r_mode == ptme_pkg::MODE_MAP)
        else $error("out of frames reported for an unmap");

    a_tlb_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_tlb_invalidate |-> o_status == ptme_pkg::STAT_DONE &&
        r_mode == ptme_pkg::MODE_UNMAP)
        else $error("tlb invalidate without a cleared leaf");

    a_alloc_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ptme_pkg::ST_CHECK && alloc |=> r_next_free == $past(r_next_free) + CW'(1))
        else $error("link written without taking a frame");

endmodule

// ----- tb/sv/page_table_map_unmap_engine_checker.sv -----
// checker for the page table engine: tracks table state, predicts each walk, compares results
`timescale 1ns / 100ps

module page_table_map_unmap_engine_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             i_mode,
    input  logic [ptme_pkg::VPN_W-1:0]       i_virt_page,
    input  logic [ptme_pkg::PFN_W-1:0]       i_phys_frame,
    input  logic [ptme_pkg::FLAGS_W-1:0]     i_leaf_flags,
    input  logic                             i_no_execute,
    input  logic                             o_done,
    input  logic [1:0]                       o_status,
    input  logic                             o_tlb_invalidate,
    input  logic [6:0]                       o_frames_in_use,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ptme_pkg::PFN_W-1:0]       i_cfg_data,
    output int                               o_mismatches,
    output int                               o_pending
);

    typedef struct packed {
        ptme_pkg::t_status status;
        logic              tlb;
        logic [6:0]        frames;
    } t_walk_result;

    logic [ptme_pkg::ENTRY_W-1:0] table_words [ptme_pkg::STORE_DEPTH];
    int unsigned                  frames_taken;
    logic [ptme_pkg::PFN_W-1:0]   pool_base;
    logic [ptme_pkg::LIMIT_W-1:0] frame_limit;
    t_walk_result                 expected_walks [$];
    int                           mismatch_count;

    // present entry pointing at a frame already handed out
    function automatic bit follow_link(input int unsigned tab,
                                       input logic [ptme_pkg::IDX_W-1:0] ix,
                                       output int unsigned child);
        logic [ptme_pkg::ENTRY_W-1:0] e;
        logic [ptme_pkg::PFN_W-1:0]   idx;
        e = table_words[tab * ptme_pkg::ENTRIES_PER_TABLE + ix];
        if (!e[0]) return 1'b0;
        idx = e[ptme_pkg::PFN_W+11:12] - pool_base;
        if (idx >= frames_taken) return 1'b0;
        child = 32'(idx);
        return 1'b1;
    endfunction

    function automatic bit take_frame(input int unsigned tab,
                                      input logic [ptme_pkg::IDX_W-1:0] ix,
                                      output int unsigned child);
        int unsigned                lim;
        logic [ptme_pkg::PFN_W-1:0] pfn;
        lim = (frame_limit < ptme_pkg::POOL_FRAMES) ? frame_limit : ptme_pkg::POOL_FRAMES;
        if (frames_taken >= lim) return 1'b0;
        pfn = pool_base + ptme_pkg::PFN_W'(frames_taken);
        table_words[tab * ptme_pkg::ENTRIES_PER_TABLE + ix] =
            {12'h000, pfn, ptme_pkg::LINK_FLAGS};
        child = frames_taken;
        frames_taken = frames_taken + 1;
        return 1'b1;
    endfunction

    function automatic t_walk_result apply_walk(input logic m,
                                                input logic [ptme_pkg::VPN_W-1:0] vp,
                                                input logic [ptme_pkg::PFN_W-1:0] pfn,
                                                input logic [ptme_pkg::FLAGS_W-1:0] flags,
                                                input logic nx);
        logic [3:0][ptme_pkg::IDX_W-1:0] ix;
        int unsigned                     tab;
        int unsigned                     child;
        int                              lvl;
        t_walk_result                    r;
        ix[0]    = vp[35:27];
        ix[1]    = vp[26:18];
        ix[2]    = vp[17:9];
        ix[3]    = vp[8:0];
        r.status = ptme_pkg::STAT_DONE;
        r.tlb    = 1'b0;
        tab      = 0;
        child    = 0;
        for (lvl = 0; lvl < 3; lvl++) begin
            if (!follow_link(tab, ix[lvl], child)) begin
                if (m == ptme_pkg::MODE_UNMAP) begin
                    r.status = ptme_pkg::STAT_NO_MAP;
                    break;
                end
                if (!take_frame(tab, ix[lvl], child)) begin
                    r.status = ptme_pkg::STAT_NO_FRAME;
                    break;
                end
            end
            tab = child;
        end
        if (r.status == ptme_pkg::STAT_DONE) begin
            if (m == ptme_pkg::MODE_MAP) begin
                table_words[tab * ptme_pkg::ENTRIES_PER_TABLE + ix[3]] =
                    {nx, 11'b0, pfn, flags};
            end else begin
                table_words[tab * ptme_pkg::ENTRIES_PER_TABLE + ix[3]] = '0;
                r.tlb = 1'b1;
            end
        end
        r.frames = 7'(frames_taken);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_walk_result exp_r;
        if (!i_rst_n) begin
            for (int k = 0; k < ptme_pkg::STORE_DEPTH; k++) table_words[k] = '0;
            frames_taken   = 1;
            pool_base      = '0;
            frame_limit    = 7'd64;
            mismatch_count = 0;
            expected_walks.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ptme_pkg::CFG_POOL_BASE:   pool_base = i_cfg_data;
                    ptme_pkg::CFG_FRAME_LIMIT: frame_limit = i_cfg_data[ptme_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (o_done) begin
                if (expected_walks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request pending: %s %0d tlb %0d frames %0d",
                                 $realtime, "status", o_status, o_tlb_invalidate,
                                 o_frames_in_use);
                end else begin
                    exp_r = expected_walks.pop_front();
                    if (o_status !== exp_r.status || o_tlb_invalidate !== exp_r.tlb ||
                        o_frames_in_use !== exp_r.frames) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch: expected status %0d tlb %0d frames %0d,",
                                     $realtime, exp_r.status, exp_r.tlb, exp_r.frames,
                                     " got status %0d tlb %0d frames %0d",
                                     o_status, o_tlb_invalidate, o_frames_in_use);
                    end
                end
            end
            if (start && !busy)
                expected_walks.push_back(apply_walk(i_mode, i_virt_page, i_phys_frame,
                                                    i_leaf_flags, i_no_execute));
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_walks.size();
    end

endmodule

// ----- tb/sv/page_table_map_unmap_engine_tb.sv -----
// testbench top for the page table engine: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module page_table_map_unmap_engine_tb;

    localparam int WALK_LATENCY  = 8;
    localparam int STALL_LIMIT   = 100000;
    localparam logic [ptme_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ptme_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           start            = 1'b0;
    logic                           busy;
    logic                           i_mode           = ptme_pkg::MODE_MAP;
    logic [ptme_pkg::VPN_W-1:0]     i_virt_page      = '0;
    logic [ptme_pkg::PFN_W-1:0]     i_phys_frame     = '0;
    logic [ptme_pkg::FLAGS_W-1:0]   i_leaf_flags     = '0;
    logic                           i_no_execute     = 1'b0;
    logic                           o_done;
    logic [1:0]                     o_status;
    logic                           o_tlb_invalidate;
    logic [6:0]                     o_frames_in_use;
    logic                           i_cfg_valid      = 1'b0;
    logic                           o_cfg_ready;
    logic [ptme_pkg::CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [ptme_pkg::PFN_W-1:0]     i_cfg_data       = '0;

    int                   mismatches;
    int                   walks_pending;
    int                   stall_cycles     = 0;
    bit                   pauses_on        = 1'b1;
    logic [26:0]          hot_prefix [6];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    page_table_map_unmap_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_virt_page(i_virt_page), .i_phys_frame(i_phys_frame),
        .i_leaf_flags(i_leaf_flags), .i_no_execute(i_no_execute),
        .o_done(o_done), .o_status(o_status), .o_tlb_invalidate(o_tlb_invalidate),
        .o_frames_in_use(o_frames_in_use),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    page_table_map_unmap_engine_checker walk_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_virt_page(i_virt_page), .i_phys_frame(i_phys_frame),
        .i_leaf_flags(i_leaf_flags), .i_no_execute(i_no_execute),
        .o_done(o_done), .o_status(o_status), .o_tlb_invalidate(o_tlb_invalidate),
        .o_frames_in_use(o_frames_in_use),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_mismatches(mismatches), .o_pending(walks_pending)
    );

    // watchdog: any accepted request, result or register write restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[page_table_map_unmap_engine] ERROR");
            $finish;
        end
    end

    task automatic maybe_pause();
        if (pauses_on && $urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic issue_walk(input logic m, input logic [ptme_pkg::VPN_W-1:0] vp,
                              input logic [ptme_pkg::PFN_W-1:0] pfn,
                              input logic [ptme_pkg::FLAGS_W-1:0] flags,
                              input logic nx);
        maybe_pause();
        i_mode       <= m;
        i_virt_page  <= vp;
        i_phys_frame <= pfn;
        i_leaf_flags <= flags;
        i_no_execute <= nx;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ptme_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptme_pkg::PFN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (walks_pending != 0) @(posedge i_clk);
        repeat (2 * WALK_LATENCY) @(posedge i_clk);
    endtask

    // mostly reuse a few hot upper paths so the walks go deep without draining the pool
    task automatic run_random(input int count, input int quiet);
        int                         k;
        int                         pick;
        logic [ptme_pkg::VPN_W-1:0] vp;
        logic                       m;
        for (k = 0; k < count; k++) begin
            pauses_on = (k >= quiet);
            pick = $urandom_range(0, 99);
            if (pick < 80)
                vp = {hot_prefix[$urandom_range(0, 5)], 9'($urandom_range(0, 15))};
            else if (pick < 90)
                vp = {hot_prefix[$urandom_range(0, 5)][26:18], 9'($urandom_range(0, 3)),
                      9'($urandom), 9'($urandom)};
            else
                vp = ptme_pkg::VPN_W'({$urandom, $urandom});
            m = ($urandom_range(0, 99) < 40) ? ptme_pkg::MODE_UNMAP : ptme_pkg::MODE_MAP;
            issue_walk(m, vp, ptme_pkg::PFN_W'({$urandom, $urandom}),
                       ptme_pkg::FLAGS_W'($urandom), 1'($urandom));
        end
        pauses_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pool base near the top so frame numbers wrap, no table frames at first
        write_reg(ptme_pkg::CFG_POOL_BASE, 40'hFF_FFFF_FFFE);
        write_reg(ptme_pkg::CFG_FRAME_LIMIT, '0);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, 40'h55_5555_5555);

        issue_walk(ptme_pkg::MODE_MAP, '0, '0, '0, 1'b0);
        issue_walk(ptme_pkg::MODE_UNMAP, '0, '0, '0, 1'b0);
        wait_drained();

        // room for one link only: the walk dies one level down, link stays
        write_reg(ptme_pkg::CFG_FRAME_LIMIT, 40'd2);
        issue_walk(ptme_pkg::MODE_MAP, '1, '1, '1, 1'b1);
        issue_walk(ptme_pkg::MODE_UNMAP, '1, '0, '0, 1'b0);
        wait_drained();

        write_reg(ptme_pkg::CFG_FRAME_LIMIT, 40'd127);
        issue_walk(ptme_pkg::MODE_MAP, '1, '1, '1, 1'b1);
        issue_walk(ptme_pkg::MODE_MAP, '0, '0, '0, 1'b0);
        issue_walk(ptme_pkg::MODE_MAP, '0, 40'h12_3456_789A, 12'h001, 1'b1);
        issue_walk(ptme_pkg::MODE_UNMAP, '0, '0, '0, 1'b0);
        issue_walk(ptme_pkg::MODE_UNMAP, '0, '0, '0, 1'b0);
        issue_walk(ptme_pkg::MODE_UNMAP, 36'h0_0000_0001, '0, '0, 1'b0);
        issue_walk(ptme_pkg::MODE_UNMAP, {9'h000, 9'h001, 18'h0}, '0, '0, 1'b0);
        issue_walk(ptme_pkg::MODE_MAP, {9'h1FF, 9'h1FF, 9'h000, 9'h005}, 40'h55_5555_5555,
                   12'hAAA, 1'b0);
        issue_walk(ptme_pkg::MODE_MAP, 36'hA_AAAA_AAAA, 40'hAA_AAAA_AAAA, 12'h555, 1'b1);
        issue_walk(ptme_pkg::MODE_UNMAP, 36'hA_AAAA_AAAA, '1, '1, 1'b1);
        issue_walk(ptme_pkg::MODE_UNMAP, '1, '0, '0, 1'b0);
        wait_drained();

        hot_prefix[0] = '1;
        hot_prefix[1] = '0;
        for (int k = 2; k < 6; k++) hot_prefix[k] = 27'($urandom);

        write_reg(ptme_pkg::CFG_FRAME_LIMIT, 40'($urandom_range(20, 48)));
        run_random(150, 0);
        wait_drained();

        // shifting the base by one makes existing links alias other frames
        write_reg(ptme_pkg::CFG_POOL_BASE, 40'hFF_FFFF_FFFF);
        write_reg(ptme_pkg::CFG_FRAME_LIMIT, 40'($urandom_range(0, 56)));
        run_random(150, 60);
        wait_drained();

        // base back to zero: links to the two frames at the top of the frame numbers now fall outside the pool
        write_reg(ptme_pkg::CFG_POOL_BASE, '0);
        write_reg(ptme_pkg::CFG_FRAME_LIMIT, 40'd64);
        write_reg(CFG_SPARE_B, ptme_pkg::PFN_W'({$urandom, $urandom}));
        run_random(150, 0);
        wait_drained();

        if (mismatches == 0 && walks_pending == 0) begin
            $display("[page_table_map_unmap_engine] OK");
        end else begin
            $display("[page_table_map_unmap_engine] ERROR");
        end
        $finish;
    end

endmodule
